FILE: hdl/mrsq_pkg.sv
// Shared types and constants of the multi-ring slot message queue.
package mrsq_pkg;

  localparam int ACTION_W   = 3;
  localparam int BYTES_W    = 16;
  localparam int RING_W     = 2;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 3;
  localparam int SLOTS_W    = 11;
  localparam int DESC_W     = RING_W + SLOT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ELEM_BASE  = 4;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 5;

  localparam logic [SLOTS_W-1:0] SLOTS_RESET     = 11'd16;
  localparam logic [BYTES_W-1:0] ELEM_RESET_BASE = 16'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC_SIZE = 3'd0,
    ACT_ALLOC_RING = 3'd1,
    ACT_FREE       = 3'd2,
    ACT_ENQUEUE    = 3'd3,
    ACT_DEQUEUE    = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_INVALID = 3'd3,
    ST_ORDER   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: hdl/mrsq_in_if.sv
// Request channel of the message queue.
interface mrsq_in_if;
  logic                         valid;
  logic                         ready;
  logic [mrsq_pkg::ACTION_W-1:0] action;
  logic [mrsq_pkg::BYTES_W-1:0]  request_bytes;
  logic [mrsq_pkg::RING_W-1:0]   ring_sel;
  logic [mrsq_pkg::SLOT_W-1:0]   slot_sel;

  modport source (output valid, action, request_bytes, ring_sel, slot_sel, input ready);
  modport sink (input valid, action, request_bytes, ring_sel, slot_sel, output ready);
endinterface

FILE: hdl/mrsq_out_if.sv
// Result channel of the message queue.
interface mrsq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mrsq_pkg::STATUS_W-1:0] status;
  logic [mrsq_pkg::RING_W-1:0]   out_ring;
  logic [mrsq_pkg::SLOT_W-1:0]   out_slot;
  logic                          wake_signal;

  modport source (output valid, status, out_ring, out_slot, wake_signal, input ready);
  modport sink (input valid, status, out_ring, out_slot, wake_signal, output ready);
endinterface

FILE: hdl/mrsq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrsq_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/mrsq_mod_unit.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 11-bit divisor.
module mrsq_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrsq_pkg::div_ctl_t         ctl,
  input  logic [mrsq_pkg::DIV_W-1:0] dividend,
  input  logic [mrsq_pkg::SLOTS_W-1:0] divisor,
  output logic [mrsq_pkg::SLOTS_W-1:0] remainder,
  output mrsq_pkg::div_sts_t         sts
);
  import mrsq_pkg::*;

  div_state_t             state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic [DIV_W-1:0]       dvd_r;
  logic [SLOTS_W-1:0]     dvs_r;
  logic [SLOTS_W-1:0]     rem_r;
  logic [SLOTS_W:0]       trial;
  logic [SLOTS_W-1:0]     rem_step;
  logic                   load;
  logic                   step;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (ctl.start) state_nxt = DIV_RUN;
      DIV_RUN:  if (cnt_r == DIV_CNT_W'(DIV_W - 1)) state_nxt = DIV_DONE;
      DIV_DONE: if (ctl.ack) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    step     = 1'b0;
    sts.busy = 1'b0;
    sts.done = 1'b0;
    unique case (state_r)
      DIV_IDLE: load = ctl.start;
      DIV_RUN: begin
        step     = 1'b1;
        sts.busy = 1'b1;
      end
      DIV_DONE: sts.done = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    trial = {rem_r, dvd_r[DIV_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_step = SLOTS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_step = trial[SLOTS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        cnt_r <= '0;
      end else if (step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (step) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

  assign remainder = rem_r;

endmodule

FILE: hdl/multi_ring_slot_message_queue.sv
// Multi-ring slot message queue: size-class slot rings and a descriptor FIFO.
// A request is taken into an input register and its result lands in an output
// register; one transaction is accepted every cycle while the result side keeps
// up. One case is slower: an enqueue into a ring whose head or tail still sits
// at or beyond a lowered slot count needs a true remainder of its window
// distance, which the two 32-step bit-serial remainder units supply, and that
// transaction holds the input register until both units are done. The
// descriptor FIFO lives in a RAM with a registered read port that is steered
// to the next head, so dequeue results come out at full rate; its entries are
// undefined after reset and need no clearing pass.
module multi_ring_slot_message_queue #(
  parameter int NUM_RINGS   = 4,
  parameter int MAX_SLOTS   = 1024,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mrsq_in_if.sink                         in_ch,
  mrsq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mrsq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrsq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mrsq_pkg::*;

  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [SLOTS_W-1:0] slots_r [NUM_RINGS];
  logic [BYTES_W-1:0] elem_r  [NUM_RINGS];

  logic [SW-1:0] head_r  [NUM_RINGS];
  logic [SW-1:0] head_nxt [NUM_RINGS];
  logic [SW-1:0] tail_r  [NUM_RINGS];
  logic [SW-1:0] tail_nxt [NUM_RINGS];
  logic [CW-1:0] count_r [NUM_RINGS];
  logic [CW-1:0] count_nxt [NUM_RINGS];

  logic [QAW-1:0] qhead_r, qhead_nxt;
  logic [QAW-1:0] qtail_r, qtail_nxt;
  logic [QCW-1:0] qcount_r, qcount_nxt;

  logic                in_vld_r;
  logic [ACTION_W-1:0] in_action_r;
  logic [BYTES_W-1:0]  in_req_r;
  logic [RING_W-1:0]   in_ri_r;
  logic [SLOT_W-1:0]   in_elt_r;

  logic                out_vld_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [RING_W-1:0]   out_ring_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_wake_r;

  logic               out_room;
  logic               fire;
  action_t            act;

  logic [SLOTS_W-1:0] n_c     [NUM_RINGS];
  logic [NUM_RINGS-1:0] full_v;
  logic [SW-1:0]      head_wr [NUM_RINGS];
  logic [SW-1:0]      tail_wr [NUM_RINGS];
  logic [NUM_RINGS-1:0] sel;
  logic [NUM_RINGS-1:0] size_fit;
  logic [NUM_RINGS-1:0] size_grant;
  logic [RING_W-1:0]  size_ring;
  logic [SLOT_W-1:0]  size_slot;

  logic [SLOTS_W-1:0] s_n;
  logic [SW-1:0]      s_head;
  logic [SW-1:0]      s_tail;
  logic [CW-1:0]      s_count;
  logic               s_full;
  logic               ri_ok;
  logic [SLOTS_W-1:0] elt_ext;

  logic [SLOTS_W:0]   v1, v2, fast1, fast2, d1, d2;
  logic               slow1, slow2, need_slow, win_ok;
  logic [DIV_W-1:0]   dvd1, dvd2;
  logic [SLOTS_W-1:0] rem1, rem2;
  div_ctl_t           div_ctl;
  div_sts_t           div_sts1, div_sts2;
  logic               div_done;
  logic               div_busy;

  logic               q_full, q_empty;
  logic [DESC_W-1:0]  q_rdata, q_head_desc;
  logic               byp_hit_r;
  logic [DESC_W-1:0]  byp_data_r;
  logic               q_we;
  logic [DESC_W-1:0]  q_wdata;

  status_t            res_status;
  logic [RING_W-1:0]  res_ring;
  logic [SLOT_W-1:0]  res_slot;
  logic               res_wake;
  logic [NUM_RINGS-1:0] alloc_v;
  logic [NUM_RINGS-1:0] free_v;
  logic               q_push, q_pop;

  assign out_room    = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && out_room && (!need_slow || div_done);
  assign in_ch.ready = !in_vld_r || fire;
  assign act         = action_t'(in_action_r);

  // Per-ring derived values
  always_comb begin
    for (int r = 0; r < NUM_RINGS; r++) begin
      n_c[r] = (slots_r[r] > SLOTS_W'(MAX_SLOTS)) ? SLOTS_W'(MAX_SLOTS) : slots_r[r];
      full_v[r] = SLOTS_W'(count_r[r]) >= n_c[r];
      head_wr[r] = ((SLOTS_W'(head_r[r]) + 1'b1) >= n_c[r]) ? '0 : SW'(head_r[r] + 1'b1);
      tail_wr[r] = ((SLOTS_W'(tail_r[r]) + 1'b1) >= n_c[r]) ? '0 : SW'(tail_r[r] + 1'b1);
      sel[r] = in_ri_r == RING_W'(r);
      size_fit[r] = (n_c[r] != '0) && (elem_r[r] >= in_req_r) && !full_v[r];
    end
  end

  // Lowest fitting ring wins
  always_comb begin
    size_grant = '0;
    size_ring  = '0;
    size_slot  = '0;
    for (int r = NUM_RINGS - 1; r >= 0; r--) begin
      if (size_fit[r]) begin
        size_grant    = '0;
        size_grant[r] = 1'b1;
        size_ring     = RING_W'(r);
        size_slot     = SLOT_W'(tail_r[r]);
      end
    end
  end

  always_comb begin
    s_n     = '0;
    s_head  = '0;
    s_tail  = '0;
    s_count = '0;
    s_full  = 1'b0;
    for (int r = 0; r < NUM_RINGS; r++) begin
      if (sel[r]) begin
        s_n     = n_c[r];
        s_head  = head_r[r];
        s_tail  = tail_r[r];
        s_count = count_r[r];
        s_full  = full_v[r];
      end
    end
  end

  assign ri_ok   = {1'b0, in_ri_r} < (RING_W + 1)'(NUM_RINGS);
  assign elt_ext = SLOTS_W'(in_elt_r);

  // Occupied-window check: fast compare-subtract, slow path through the remainder units
  always_comb begin
    v1    = (SLOTS_W + 1)'(s_n) + (SLOTS_W + 1)'(in_elt_r) - (SLOTS_W + 1)'(s_head);
    v2    = (SLOTS_W + 1)'(s_n) + (SLOTS_W + 1)'(s_tail) - (SLOTS_W + 1)'(s_head);
    slow1 = (SLOTS_W + 1)'(s_head) > ((SLOTS_W + 1)'(s_n) + (SLOTS_W + 1)'(in_elt_r));
    slow2 = (s_tail != s_head) &&
            (((SLOTS_W + 1)'(s_head) > ((SLOTS_W + 1)'(s_n) + (SLOTS_W + 1)'(s_tail))) ||
             (v2 >= {s_n, 1'b0}));
    fast1 = (v1 >= (SLOTS_W + 1)'(s_n)) ? v1 - (SLOTS_W + 1)'(s_n) : v1;
    fast2 = (v2 >= (SLOTS_W + 1)'(s_n)) ? v2 - (SLOTS_W + 1)'(s_n) : v2;
    d1    = slow1 ? (SLOTS_W + 1)'(rem1) : fast1;
    if (s_tail == s_head) begin
      d2 = (s_count == '0) ? '0 : (SLOTS_W + 1)'(s_n);
    end else begin
      d2 = slow2 ? (SLOTS_W + 1)'(rem2) : fast2;
    end
    dvd1 = DIV_W'(s_n) + DIV_W'(in_elt_r) - DIV_W'(s_head);
    dvd2 = DIV_W'(s_n) + DIV_W'(s_tail) - DIV_W'(s_head);
    win_ok    = ri_ok && (s_n != '0) && (elt_ext < s_n) && (d1 < d2);
    need_slow = (act == ACT_ENQUEUE) && ri_ok && (s_n != '0) && (elt_ext < s_n) &&
                (slow1 || slow2);
  end

  assign div_done      = div_sts1.done && div_sts2.done;
  assign div_busy      = div_sts1.busy || div_sts2.busy;
  assign div_ctl.start = in_vld_r && need_slow && !div_busy && !div_done;
  assign div_ctl.ack   = fire && need_slow;

  mrsq_mod_unit u_mod_elt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (dvd1),
    .divisor   (s_n),
    .remainder (rem1),
    .sts       (div_sts1)
  );

  mrsq_mod_unit u_mod_tail (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (dvd2),
    .divisor   (s_n),
    .remainder (rem2),
    .sts       (div_sts2)
  );

  assign q_full      = qcount_r >= QCW'(QUEUE_DEPTH);
  assign q_empty     = qcount_r == '0;
  assign q_head_desc = byp_hit_r ? byp_data_r : q_rdata;

  always_comb begin
    res_status = ST_INVALID;
    res_ring   = '0;
    res_slot   = '0;
    res_wake   = 1'b0;
    alloc_v    = '0;
    free_v     = '0;
    q_push     = 1'b0;
    q_pop      = 1'b0;
    unique case (act)
      ACT_ALLOC_SIZE: begin
        if (size_grant != '0) begin
          res_status = ST_OK;
          res_ring   = size_ring;
          res_slot   = size_slot;
          alloc_v    = size_grant;
        end else begin
          res_status = ST_FULL;
        end
      end
      ACT_ALLOC_RING: begin
        if (!ri_ok) begin
          res_status = ST_INVALID;
        end else if (q_full || s_full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_ring   = in_ri_r;
          res_slot   = SLOT_W'(s_tail);
          alloc_v    = sel;
        end
      end
      ACT_FREE: begin
        if (!ri_ok || (s_n == '0) || (elt_ext >= s_n)) begin
          res_status = ST_INVALID;
        end else if (s_count == '0) begin
          res_status = ST_EMPTY;
        end else if (elt_ext != SLOTS_W'(s_head)) begin
          res_status = ST_ORDER;
        end else begin
          res_status = ST_OK;
          res_wake   = s_full;
          free_v     = sel;
        end
      end
      ACT_ENQUEUE: begin
        if (!win_ok) begin
          res_status = ST_INVALID;
        end else if (q_full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_wake   = q_empty;
          q_push     = 1'b1;
        end
      end
      ACT_DEQUEUE: begin
        if (q_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_status = ST_OK;
          res_ring   = q_head_desc[DESC_W-1:SLOT_W];
          res_slot   = q_head_desc[SLOT_W-1:0];
          res_wake   = q_full;
          q_pop      = 1'b1;
        end
      end
      default: res_status = ST_INVALID;
    endcase
  end

  // Next state, advanced only when the transaction completes
  always_comb begin
    for (int r = 0; r < NUM_RINGS; r++) begin
      head_nxt[r]  = head_r[r];
      tail_nxt[r]  = tail_r[r];
      count_nxt[r] = count_r[r];
      if (fire && alloc_v[r]) begin
        tail_nxt[r]  = tail_wr[r];
        count_nxt[r] = count_r[r] + 1'b1;
      end else if (fire && free_v[r]) begin
        head_nxt[r]  = head_wr[r];
        count_nxt[r] = count_r[r] - 1'b1;
      end
    end
    qhead_nxt  = qhead_r;
    qtail_nxt  = qtail_r;
    qcount_nxt = qcount_r;
    if (fire && q_push) begin
      qtail_nxt  = (qtail_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : qtail_r + 1'b1;
      qcount_nxt = qcount_r + 1'b1;
    end else if (fire && q_pop) begin
      qhead_nxt  = (qhead_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : qhead_r + 1'b1;
      qcount_nxt = qcount_r - 1'b1;
    end
  end

  assign q_we    = fire && q_push;
  assign q_wdata = {in_ri_r, in_elt_r};

  mrsq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qtail_r),
    .wdata (q_wdata),
    .raddr (qhead_nxt),
    .rdata (q_rdata)
  );

  // Forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    byp_data_r <= q_wdata;
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else begin
      byp_hit_r <= q_we && (qtail_r == qhead_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_RINGS; r++) begin
        slots_r[r] <= SLOTS_RESET;
        elem_r[r]  <= BYTES_W'(ELEM_RESET_BASE << r);
      end
    end else if (cfg_we) begin
      for (int r = 0; r < NUM_RINGS; r++) begin
        if (cfg_index == CFG_IDX_W'(r)) begin
          slots_r[r] <= cfg_data[SLOTS_W-1:0];
        end
        if (cfg_index == CFG_IDX_W'(ELEM_BASE + r)) begin
          elem_r[r] <= cfg_data[BYTES_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_RINGS; r++) begin
        head_r[r]  <= '0;
        tail_r[r]  <= '0;
        count_r[r] <= '0;
      end
      qhead_r  <= '0;
      qtail_r  <= '0;
      qcount_r <= '0;
    end else begin
      for (int r = 0; r < NUM_RINGS; r++) begin
        head_r[r]  <= head_nxt[r];
        tail_r[r]  <= tail_nxt[r];
        count_r[r] <= count_nxt[r];
      end
      qhead_r  <= qhead_nxt;
      qtail_r  <= qtail_nxt;
      qcount_r <= qcount_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_action_r <= in_ch.action;
      in_req_r    <= in_ch.request_bytes;
      in_ri_r     <= in_ch.ring_sel;
      in_elt_r    <= in_ch.slot_sel;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_room) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r <= res_status;
      out_ring_r   <= res_ring;
      out_slot_r   <= res_slot;
      out_wake_r   <= res_wake;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_ring    = out_ring_r;
  assign out_ch.out_slot    = out_slot_r;
  assign out_ch.wake_signal = out_wake_r;

endmodule
